// File: design/tea_pkg.sv
// ----------------------------------------------------------------------------
// tea_pkg
// Shared types, constants and the round mixing function of the TEA engine.
// ----------------------------------------------------------------------------
package tea_pkg;

    // Cipher constants
    localparam int unsigned TEA_ROUNDS    = 32;
    localparam int unsigned TEA_KEY_WORDS = 4;
    localparam logic [31:0] TEA_DELTA     = 32'h9E37_79B9;

    // Register map, word index on the configuration port
    localparam int unsigned TEA_ADDR_W = 4;
    typedef enum logic [1:0] {
        REG_KEY0 = 2'd0,
        REG_KEY1 = 2'd1,
        REG_KEY2 = 2'd2,
        REG_KEY3 = 2'd3
    } tea_reg_t;

    // Operation selector carried in tuser
    typedef enum logic {
        FUNC_ENC = 1'b0,
        FUNC_DEC = 1'b1
    } tea_func_t;

    // 128-bit key as four words
    typedef logic [TEA_KEY_WORDS-1:0][31:0] tea_key_t;

    // Payload carried from stage to stage
    typedef struct packed {
        tea_func_t   func;
        logic [31:0] a;
        logic [31:0] b;
    } tea_stage_t;

    // Running sum after n delta steps, wrapping at 32 bits
    function automatic logic [31:0] tea_sum(input int unsigned n);
        logic [63:0] p;
        p = 64'(TEA_DELTA) * 64'(n);
        return p[31:0];
    endfunction

    // F-function of one half round
    function automatic logic [31:0] tea_mix(input logic [31:0] v,
                                            input logic [31:0] sum,
                                            input logic [31:0] ka,
                                            input logic [31:0] kb);
        logic [31:0] x;
        logic [31:0] y;
        logic [31:0] z;
        x = (v << 4) + ka;
        y = v + sum;
        z = (v >> 5) + kb;
        return x ^ y ^ z;
    endfunction

endpackage

// File: design/tea_cfg.sv
// ----------------------------------------------------------------------------
// tea_cfg
// APB register file holding the four key words.
// ----------------------------------------------------------------------------
module tea_cfg
    import tea_pkg::*;
(
    input  logic                  aclk,
    input  logic                  aresetn,
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [TEA_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready,
    output tea_key_t              key
);

    tea_key_t key_reg;
    tea_key_t key_next;
    tea_reg_t reg_idx;
    logic     wr_en;

    assign pready  = 1'b1;
    assign reg_idx = tea_reg_t'(paddr[TEA_ADDR_W-1:2]);
    assign wr_en   = psel && penable && pwrite;

    // Write decode
    always_comb begin
        key_next = key_reg;
        if (wr_en) begin
            case (reg_idx)
                REG_KEY0: key_next[0] = pwdata;
                REG_KEY1: key_next[1] = pwdata;
                REG_KEY2: key_next[2] = pwdata;
                REG_KEY3: key_next[3] = pwdata;
                default:  key_next = key_reg;
            endcase
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            key_reg <= '0;
        end else begin
            key_reg <= key_next;
        end
    end

    // Read mux
    always_comb begin
        case (reg_idx)
            REG_KEY0: prdata = key_reg[0];
            REG_KEY1: prdata = key_reg[1];
            REG_KEY2: prdata = key_reg[2];
            REG_KEY3: prdata = key_reg[3];
            default:  prdata = '0;
        endcase
    end

    assign key = key_reg;

endmodule

// File: design/tea_half_round.sv
// ----------------------------------------------------------------------------
// tea_half_round
// One registered half round: updates one half of the block with the
// F-function of the other half. Encrypt adds, decrypt subtracts.
// ----------------------------------------------------------------------------
module tea_half_round
    import tea_pkg::*;
#(
    parameter logic [31:0] SUM_ENC = TEA_DELTA,
    parameter logic [31:0] SUM_DEC = TEA_DELTA,
    parameter bit          PHASE   = 1'b0
)(
    input  logic       aclk,
    input  logic       aresetn,
    input  tea_key_t   key,
    input  logic       in_valid,
    output logic       in_ready,
    input  tea_stage_t in_data,
    output logic       out_valid,
    input  logic       out_ready,
    output tea_stage_t out_data
);

    logic        valid_reg;
    logic        valid_next;
    tea_stage_t  data_reg;
    tea_stage_t  data_next;
    logic        upd_first;
    logic        is_dec;
    logic [31:0] f_val;
    logic [31:0] tgt;
    logic [31:0] res;

    // Stage takes a new item when empty or when its item moves on
    assign in_ready = !valid_reg || out_ready;
    assign is_dec   = (in_data.func == FUNC_DEC);

    // Encrypt: first phase updates a, second updates b; decrypt the reverse
    assign upd_first = (PHASE == 1'b0) ? !is_dec : is_dec;

    always_comb begin
        if (upd_first) begin
            f_val = tea_mix(in_data.b, is_dec ? SUM_DEC : SUM_ENC, key[0], key[1]);
            tgt   = in_data.a;
        end else begin
            f_val = tea_mix(in_data.a, is_dec ? SUM_DEC : SUM_ENC, key[2], key[3]);
            tgt   = in_data.b;
        end
        res = is_dec ? (tgt - f_val) : (tgt + f_val);

        data_next = in_data;
        if (upd_first) begin
            data_next.a = res;
        end else begin
            data_next.b = res;
        end
        valid_next = in_ready ? in_valid : valid_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            valid_reg <= 1'b0;
        end else begin
            valid_reg <= valid_next;
        end
    end

    // Payload, no reset
    always_ff @(posedge aclk) begin
        if (in_ready && in_valid) begin
            data_reg <= data_next;
        end
    end

    assign out_valid = valid_reg;
    assign out_data  = data_reg;

endmodule

// File: design/tea_block_cipher.sv
// ----------------------------------------------------------------------------
// tea_block_cipher
// Pipelined TEA (64-bit block, 128-bit key) encrypt/decrypt engine.
//
//  Port group      Dir  Contents
//  s_*  (stream)   in   tdata: block_first[31:0], block_second[63:32];
//                       tuser: func (0 encrypt, 1 decrypt)
//  m_*  (stream)   out  tdata: result_first[31:0], result_second[63:32]
//  APB             in   key_word0..3 at byte addresses 0x0, 0x4, 0x8, 0xC
//
// Throughput is one block per cycle while the output is not stalled; the
// pipeline has one register stage per half round.
// aresetn is synchronous, active low; it empties the pipeline and clears
// the key words to zero.
// Each stage holds its block while the next one is full and stalled, so
// empty slots close up and input stays ready until every stage is full.
// ----------------------------------------------------------------------------
module tea_block_cipher
    import tea_pkg::*;
#(
    parameter int unsigned ROUNDS = TEA_ROUNDS
)(
    input  logic                  aclk,
    input  logic                  aresetn,
    // Input stream
    input  logic                  s_tvalid,
    output logic                  s_tready,
    input  logic [63:0]           s_tdata,   // block_first[31:0], block_second[63:32]
    input  logic                  s_tuser,   // func[0]
    // Result stream
    output logic                  m_tvalid,
    input  logic                  m_tready,
    output logic [63:0]           m_tdata,   // result_first[31:0], result_second[63:32]
    // Configuration
    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [TEA_ADDR_W-1:0] paddr,
    input  logic [31:0]           pwdata,
    output logic [31:0]           prdata,
    output logic                  pready
);

    localparam int unsigned STAGES = 2 * ROUNDS;
    localparam int unsigned CNT_W  = $clog2(STAGES + 1);

    tea_key_t   key;
    tea_stage_t in_item;
    tea_stage_t st_data  [STAGES];
    logic [STAGES-1:0] st_valid;
    logic [STAGES:0]   st_ready;

    // Key registers
    tea_cfg u_cfg (
        .aclk    (aclk),
        .aresetn (aresetn),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .key     (key)
    );

    assign in_item.func = tea_func_t'(s_tuser);
    assign in_item.a    = s_tdata[31:0];
    assign in_item.b    = s_tdata[63:32];

    assign st_ready[STAGES] = m_tready;
    assign s_tready         = st_ready[0];

    // Half-round stages: round r uses sum delta*(r+1) encrypting,
    // delta*(ROUNDS-r) decrypting
    for (genvar i = 0; i < STAGES; i++) begin : g_stage
        localparam int unsigned RND = i / 2;
        localparam logic [31:0] SE  = tea_sum(RND + 1);
        localparam logic [31:0] SD  = tea_sum(ROUNDS - RND);
        localparam bit          PH  = (i % 2) == 1;

        logic       v_in;
        tea_stage_t d_in;

        if (i == 0) begin : g_first
            assign v_in = s_tvalid;
            assign d_in = in_item;
        end else begin : g_next
            assign v_in = st_valid[i-1];
            assign d_in = st_data[i-1];
        end

        tea_half_round #(
            .SUM_ENC (SE),
            .SUM_DEC (SD),
            .PHASE   (PH)
        ) u_half (
            .aclk      (aclk),
            .aresetn   (aresetn),
            .key       (key),
            .in_valid  (v_in),
            .in_ready  (st_ready[i]),
            .in_data   (d_in),
            .out_valid (st_valid[i]),
            .out_ready (st_ready[i+1]),
            .out_data  (st_data[i])
        );
    end

    assign m_tvalid = st_valid[STAGES-1];
    assign m_tdata  = {st_data[STAGES-1].b, st_data[STAGES-1].a};

    // Occupancy tracking for the checks below
    logic [CNT_W-1:0] in_flight_reg;
    logic [CNT_W-1:0] in_flight_next;
    logic             s_xfer;
    logic             m_xfer;

    assign s_xfer = s_tvalid && s_tready;
    assign m_xfer = m_tvalid && m_tready;

    always_comb begin
        in_flight_next = in_flight_reg;
        if (s_xfer && !m_xfer) begin
            in_flight_next = in_flight_reg + CNT_W'(1);
        end else if (m_xfer && !s_xfer) begin
            in_flight_next = in_flight_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            in_flight_reg <= '0;
        end else begin
            in_flight_reg <= in_flight_next;
        end
    end

    // Every accepted transaction sits in exactly one stage until delivered
    a_occupancy: assert property (@(posedge aclk) disable iff (!aresetn)
        in_flight_reg == CNT_W'($countones(st_valid)))
        else $error("pipeline occupancy does not match transaction count");

    // Input is held off only when every stage is full
    a_no_bubble_stall: assert property (@(posedge aclk) disable iff (!aresetn)
        !s_tready |-> (&st_valid))
        else $error("input stalled while pipeline has an empty stage");

    // Reset empties the pipeline
    a_reset_empty: assert property (@(posedge aclk)
        !aresetn |=> (st_valid == '0))
        else $error("stage valid after reset");

endmodule

// File: bench/tb_top.sv
// ----------------------------------------------------------------------------
// tb_top
// Self-checking bench for the pipelined TEA encrypt/decrypt engine.
//
// A clocked driver feeds blocks from a pending queue onto the input stream;
// each accepted transaction is run through a bit-accurate cipher model with
// the bench's copy of the key, and the expected block is queued. A clocked
// monitor checks every result transaction, in order, against that queue.
// Keys are loaded over APB between phases, once the pipeline has drained,
// and read back. Phases cover the zero key, the all-ones key, mixed keys,
// corner blocks, encrypt/decrypt round trips and random blocks, with random
// idling on both streams and one phase at full rate.
// ----------------------------------------------------------------------------
module tb_top
    import tea_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int unsigned CIPHER_ROUNDS = TEA_ROUNDS;
    localparam int unsigned PIPE_LATENCY  = 2 * CIPHER_ROUNDS;
    localparam int unsigned PHASE_ITEMS   = 330;
    localparam int unsigned CYCLE_LIMIT   = 400000;

    // One cipher request and one 64-bit block, laid out as on tdata
    typedef struct packed {
        tea_func_t   op;
        logic [31:0] second;
        logic [31:0] first;
    } tea_request_t;

    typedef struct packed {
        logic [31:0] second;
        logic [31:0] first;
    } tea_block_t;

    logic                  aclk     = 1'b0;
    logic                  aresetn  = 1'b0;
    logic                  s_tvalid = 1'b0;
    logic                  s_tready;
    logic [63:0]           s_tdata  = '0;   // block_first[31:0], block_second[63:32]
    logic                  s_tuser  = 1'b0; // func[0]
    logic                  m_tvalid;
    logic                  m_tready = 1'b0;
    logic [63:0]           m_tdata;         // result_first[31:0], result_second[63:32]
    logic                  psel     = 1'b0;
    logic                  penable  = 1'b0;
    logic                  pwrite   = 1'b0;
    logic [TEA_ADDR_W-1:0] paddr    = '0;
    logic [31:0]           pwdata   = '0;
    logic [31:0]           prdata;
    logic                  pready;

    tea_request_t pending_blocks[$];
    tea_block_t   expected_blocks[$];
    tea_key_t     key_model   = '0;
    bit           allow_stalls = 1'b1;
    int unsigned  fail_count  = 0;
    int unsigned  cycle_cnt   = 0;

    tea_block_cipher dut (
        .aclk    (aclk),
        .aresetn (aresetn),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready)
    );

    always begin
        #6 aclk = 1'b1;
        #6 aclk = 1'b0;
    end

    // Round function: shifted copies plus key words, xored with v + sum
    function automatic logic [31:0] feistel_f(input logic [31:0] v, input logic [31:0] acc,
                                              input logic [31:0] ka, input logic [31:0] kb);
        return ((v << 4) + ka) ^ (v + acc) ^ ((v >> 5) + kb);
    endfunction

    // Full TEA encrypt or decrypt of one block under the given key
    function automatic tea_block_t tea_cipher_model(input tea_request_t req,
                                                    input tea_key_t key);
        logic [31:0] y;
        logic [31:0] z;
        logic [31:0] acc;
        int          r;
        y = req.first;
        z = req.second;
        if (req.op == FUNC_ENC) begin
            acc = '0;
            for (r = 0; r < CIPHER_ROUNDS; r++) begin
                acc = acc + TEA_DELTA;
                y = y + feistel_f(z, acc, key[0], key[1]);
                z = z + feistel_f(y, acc, key[2], key[3]);
            end
        end else begin
            // decryption starts from delta times the round count, wrapped
            acc = 32'(TEA_DELTA * CIPHER_ROUNDS);
            for (r = 0; r < CIPHER_ROUNDS; r++) begin
                z = z - feistel_f(y, acc, key[2], key[3]);
                y = y - feistel_f(z, acc, key[0], key[1]);
                acc = acc - TEA_DELTA;
            end
        end
        return {z, y};
    endfunction

    function automatic void note_failure(input string msg);
        if (fail_count < 10)
            $display("mismatch at cycle %0d: %s", cycle_cnt, msg);
        fail_count++;
    endfunction

    // Input side: account for the accepted transaction, then present the next
    always @(posedge aclk) begin
        tea_request_t nxt;
        if (!aresetn) begin
            s_tvalid <= 1'b0;
        end else begin
            if (s_tvalid && s_tready)
                expected_blocks.push_back(
                    tea_cipher_model({tea_func_t'(s_tuser), s_tdata}, key_model));
            if (!s_tvalid || s_tready) begin
                if (pending_blocks.size() != 0 &&
                    !(allow_stalls && $urandom_range(99) < 33)) begin
                    nxt = pending_blocks.pop_front();
                    s_tvalid <= 1'b1;
                    s_tdata  <= {nxt.second, nxt.first};
                    s_tuser  <= nxt.op;
                end else begin
                    s_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result side: compare each transaction with the oldest expected block
    always @(posedge aclk) begin
        tea_block_t want;
        if (!aresetn) begin
            m_tready <= 1'b0;
        end else begin
            if (m_tvalid && m_tready) begin
                if (expected_blocks.size() == 0) begin
                    note_failure($sformatf("result %h with nothing expected", m_tdata));
                end else begin
                    want = expected_blocks.pop_front();
                    if (m_tdata[31:0] !== want.first)
                        note_failure($sformatf("result_first expected %h got %h",
                                               want.first, m_tdata[31:0]));
                    if (m_tdata[63:32] !== want.second)
                        note_failure($sformatf("result_second expected %h got %h",
                                               want.second, m_tdata[63:32]));
                end
            end
            m_tready <= allow_stalls ? ($urandom_range(99) >= 33) : 1'b1;
        end
    end

    // Watchdog
    always @(posedge aclk) begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT) begin
            $display("status: fail");
            $finish;
        end
    end

    // One APB transaction; read data is sampled mid access phase
    task automatic apb_xfer(input logic wr, input tea_reg_t idx, input logic [31:0] wdata,
                            output logic [31:0] rdata);
        logic done;
        @(posedge aclk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= wr;
        paddr   <= {idx, 2'b00};
        pwdata  <= wdata;
        @(posedge aclk);
        penable <= 1'b1;
        done = 1'b0;
        rdata = '0;
        while (!done) begin
            @(negedge aclk);
            rdata = prdata;
            done  = pready;
            @(posedge aclk);
        end
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
    endtask

    // Write all four key words, then read them back
    task automatic load_key(input tea_key_t key);
        logic [31:0] rd;
        int          i;
        for (i = 0; i < TEA_KEY_WORDS; i++) begin
            apb_xfer(1'b1, tea_reg_t'(i), key[i], rd);
            key_model[i] = key[i];
        end
        for (i = 0; i < TEA_KEY_WORDS; i++) begin
            apb_xfer(1'b0, tea_reg_t'(i), '0, rd);
            if (rd !== key_model[i])
                note_failure($sformatf("key word %0d readback expected %h got %h",
                                       i, key_model[i], rd));
        end
    endtask

    // Hold until the pipeline is empty and every result has come back
    task automatic wait_drained();
        while (pending_blocks.size() != 0 || s_tvalid || expected_blocks.size() != 0)
            @(posedge aclk);
        repeat (PIPE_LATENCY + 8) @(posedge aclk);
    endtask

    // Both operations over corner blocks
    task automatic queue_corners(input logic [31:0] a0, input logic [31:0] b0,
                                 input logic [31:0] a1, input logic [31:0] b1);
        pending_blocks.push_back({FUNC_ENC, b0, a0});
        pending_blocks.push_back({FUNC_DEC, b0, a0});
        pending_blocks.push_back({FUNC_ENC, b1, a1});
        pending_blocks.push_back({FUNC_DEC, b1, a1});
    endtask

    // Encrypt a block and queue the decryption of its ciphertext right after
    task automatic queue_round_trip(input logic [31:0] a, input logic [31:0] b);
        tea_block_t ct;
        ct = tea_cipher_model({FUNC_ENC, b, a}, key_model);
        pending_blocks.push_back({FUNC_ENC, b, a});
        pending_blocks.push_back({FUNC_DEC, ct.second, ct.first});
    endtask

    function automatic logic [31:0] pick_word();
        case ($urandom_range(5))
            0:       return '0;
            1:       return '1;
            2:       return 32'h1 << $urandom_range(31);
            default: return $urandom;
        endcase
    endfunction

    // Mostly round trips with random content, the rest lone operations
    task automatic queue_random_phase(input int unsigned n);
        int unsigned cnt;
        int unsigned kind;
        cnt = 0;
        while (cnt < n) begin
            kind = $urandom_range(99);
            if (kind < 55) begin
                queue_round_trip(pick_word(), pick_word());
                cnt += 2;
            end else begin
                pending_blocks.push_back({tea_func_t'($urandom_range(1)), pick_word(),
                                          pick_word()});
                cnt++;
            end
        end
    endtask

    initial begin
        repeat (7) @(posedge aclk);
        aresetn <= 1'b1;
        @(posedge aclk);

        // Zero key straight out of reset
        queue_corners(32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        pending_blocks.push_back({FUNC_ENC, 32'hFFFF_FFFF, 32'h0000_0000});
        pending_blocks.push_back({FUNC_DEC, 32'h0000_0000, 32'hFFFF_FFFF});
        wait_drained();

        // All-ones key
        load_key('1);
        queue_corners(32'h0000_0000, 32'h0000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF);
        pending_blocks.push_back({FUNC_ENC, 32'hFFFF_FFFF, 32'h0000_0000});
        pending_blocks.push_back({FUNC_DEC, 32'h0000_0000, 32'hFFFF_FFFF});
        wait_drained();

        // Mixed key, alternating patterns and a round trip
        load_key({32'h7654_3210, 32'hFEDC_BA98, 32'h89AB_CDEF, 32'h0123_4567});
        queue_corners(32'h5555_5555, 32'hAAAA_AAAA, 32'h8000_0000, 32'h0000_0001);
        queue_round_trip(32'h0123_4567, 32'h89AB_CDEF);
        wait_drained();

        // Random phases under different keys, one of them at full rate
        load_key({$urandom, $urandom, $urandom, $urandom});
        queue_random_phase(PHASE_ITEMS);
        wait_drained();

        allow_stalls = 1'b0;
        load_key({$urandom, $urandom, $urandom, $urandom});
        queue_random_phase(PHASE_ITEMS);
        wait_drained();
        allow_stalls = 1'b1;

        load_key({32'hFFFF_FFFF, 32'h0000_0000, 32'hFFFF_FFFF, 32'h0000_0000});
        queue_random_phase(PHASE_ITEMS);
        wait_drained();

        load_key({$urandom, $urandom, $urandom, $urandom});
        queue_random_phase(PHASE_ITEMS);
        wait_drained();

        load_key({$urandom, $urandom, $urandom, $urandom});
        queue_random_phase(PHASE_ITEMS);
        wait_drained();

        if (fail_count == 0 && expected_blocks.size() == 0) begin
            $display("status: pass");
        end else begin
            $display("status: fail");
        end
        $finish;
    end

endmodule
